@@ design/scb_pkg.sv @@
`timescale 1ns / 1ps

package scb_pkg;

  // register file
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(1080);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(1920);
  localparam logic [CFG_W-1:0] ROWS_MIN   = CFG_W'(3);
  localparam logic [CFG_W-1:0] COLS_MIN   = CFG_W'(8);

  // default frame limits
  localparam int MAX_LINES_DEF  = 2048;
  localparam int MAX_PIXELS_DEF = 2048;

  // rows / 3 as (rows * 2731) >> 13, exact for any 12-bit row count
  localparam int THIRD_MUL   = 2731;
  localparam int THIRD_SHIFT = 13;
  localparam int PROD_W      = 2 * CFG_W;
  localparam int THIRD_W     = CFG_W - 1;

  // bar geometry and divider
  localparam int BAR_SHIFT = 3;
  localparam int BAR_W     = CFG_W - BAR_SHIFT;
  localparam int OFFSET_W  = 12;
  localparam int DIV_W     = OFFSET_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int IDX_W     = 3;

  localparam int COLOR_W = 8;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  typedef struct packed {
    logic calc;      // latch frame geometry and line flags
    logic prep;      // form dividend, advance counters
    logic div_step;  // one restoring division step
    logic load;      // move pixel into output register
  } scb_cmd_t;

  typedef struct packed {
    logic out_free;
  } scb_status_t;

  localparam logic [COLOR_W-1:0] C_ON  = 8'hff;
  localparam logic [COLOR_W-1:0] C_OFF = 8'h00;

  function automatic color_t bar_color(input logic [IDX_W-1:0] idx);
    color_t c;
    unique case (idx)
      3'd0: c = '{red: C_ON,  green: C_ON,  blue: C_ON};   // white
      3'd1: c = '{red: C_ON,  green: C_ON,  blue: C_OFF};  // yellow
      3'd2: c = '{red: C_OFF, green: C_ON,  blue: C_ON};   // cyan
      3'd3: c = '{red: C_OFF, green: C_ON,  blue: C_OFF};  // green
      3'd4: c = '{red: C_ON,  green: C_OFF, blue: C_ON};   // magenta
      3'd5: c = '{red: C_ON,  green: C_OFF, blue: C_OFF};  // red
      3'd6: c = '{red: C_OFF, green: C_OFF, blue: C_ON};   // blue
      3'd7: c = '{red: C_OFF, green: C_OFF, blue: C_OFF};  // black
    endcase
    return c;
  endfunction

endpackage

@@ design/scb_if.sv @@
`timescale 1ns / 1ps

interface scb_req_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface scb_pix_if;
  import scb_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] red;
  logic               start_of_frame;
  logic               end_of_line;

  modport source (output valid, output blue, output green, output red,
                  output start_of_frame, output end_of_line, input ready);
  modport sink   (input valid, input blue, input green, input red,
                  input start_of_frame, input end_of_line, output ready);
endinterface

interface scb_cfg_if;
  import scb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/scb_ctrl.sv @@
`timescale 1ns / 1ps

module scb_ctrl (
  input  logic                clk,
  input  logic                rst,
  scb_req_if.sink             req,
  input  scb_pkg::scb_status_t status,
  output scb_pkg::scb_cmd_t    cmd
);
  import scb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] step, step_next;

  assign req.ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        // a hold request is taken and dropped
        if (req.valid && req.advance) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + DIV_CNT_W'(1);
        if (step == LAST_STEP) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

@@ design/scb_datapath.sv @@
`timescale 1ns / 1ps

module scb_datapath #(
  parameter int MAX_LINES  = scb_pkg::MAX_LINES_DEF,
  parameter int MAX_PIXELS = scb_pkg::MAX_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  scb_cfg_if.sink              cfg,
  scb_pix_if.source            pix,
  input  scb_pkg::scb_cmd_t    cmd,
  output scb_pkg::scb_status_t status
);
  import scb_pkg::*;

  localparam int LINE_W = $clog2(MAX_LINES);
  localparam int PIX_W  = $clog2(MAX_PIXELS);
  localparam logic [CFG_W:0] LINES_LIM  = (CFG_W + 1)'(MAX_LINES);
  localparam logic [CFG_W:0] PIXELS_LIM = (CFG_W + 1)'(MAX_PIXELS);

  // configuration
  logic [CFG_W-1:0] frame_rows, frame_cols;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= ROWS_RESET;
      frame_cols <= COLS_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_FRAME_ROWS) begin
        frame_rows <= cfg.data;
      end else if (cfg.index == REG_FRAME_COLS) begin
        frame_cols <= cfg.data;
      end
    end
  end

  // clamped size
  logic [CFG_W-1:0]  rows, cols;
  logic [PROD_W-1:0] third_prod;

  always_comb begin
    if (frame_rows < ROWS_MIN) begin
      rows = ROWS_MIN;
    end else if ({1'b0, frame_rows} > LINES_LIM) begin
      rows = CFG_W'(LINES_LIM);
    end else begin
      rows = frame_rows;
    end
    if (frame_cols < COLS_MIN) begin
      cols = COLS_MIN;
    end else if ({1'b0, frame_cols} > PIXELS_LIM) begin
      cols = CFG_W'(PIXELS_LIM);
    end else begin
      cols = frame_cols;
    end
  end

  assign third_prod = PROD_W'(rows) * PROD_W'(THIRD_MUL);

  // frame position
  logic [LINE_W-1:0]   line_count;
  logic [PIX_W-1:0]    pixel_count;
  logic [OFFSET_W-1:0] scroll_offset;

  // latched at calc
  logic [THIRD_W-1:0] third;
  logic [CFG_W-1:0]   cols_q;
  logic               eol, eof, sof;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      third  <= third_prod[THIRD_SHIFT +: THIRD_W];
      cols_q <= cols;
      sof    <= (line_count == '0) && (pixel_count == '0);
      eol    <= (CFG_W'(pixel_count) >= cols - CFG_W'(1));
      eof    <= (CFG_W'(pixel_count) >= cols - CFG_W'(1)) &&
                (CFG_W'(line_count) >= rows - CFG_W'(1));
    end
  end

  // scroll applies only to the middle third of the lines
  logic                in_middle;
  logic [OFFSET_W-1:0] move;

  assign in_middle = (CFG_W'(line_count) >= CFG_W'(third)) &&
                     (CFG_W'(line_count) < {third, 1'b0});
  assign move      = in_middle ? scroll_offset : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= '0;
      pixel_count   <= '0;
      scroll_offset <= '0;
    end else if (cmd.prep) begin
      if (eol) begin
        pixel_count <= '0;
        if (eof) begin
          line_count <= '0;
          if (scroll_offset == '0) begin
            scroll_offset <= OFFSET_W'(cols_q);
          end else begin
            scroll_offset <= scroll_offset - OFFSET_W'(1);
          end
        end else begin
          line_count <= line_count + LINE_W'(1);
        end
      end else begin
        pixel_count <= pixel_count + PIX_W'(1);
      end
    end
  end

  // restoring divider, one quotient bit per step; only the low three
  // quotient bits are kept
  logic [DIV_W-1:0] dvd;
  logic [BAR_W-1:0] rem;
  logic [IDX_W-1:0] quo;
  logic [BAR_W-1:0] bar_w;
  logic [BAR_W:0]   rem_sh;
  logic             fits;

  assign bar_w  = cols_q[CFG_W-1:BAR_SHIFT];
  assign rem_sh = {rem, dvd[DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, bar_w});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dvd <= DIV_W'(pixel_count) + DIV_W'(move);
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[DIV_W-2:0], 1'b0};
      rem <= fits ? BAR_W'(rem_sh - {1'b0, bar_w}) : BAR_W'(rem_sh);
      quo <= {quo[IDX_W-2:0], fits};
    end
  end

  // output register
  color_t color;
  logic   out_valid;

  assign color           = bar_color(quo);
  assign status.out_free = !out_valid || pix.ready;
  assign pix.valid       = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix.red            <= color.red;
      pix.green          <= color.green;
      pix.blue           <= color.blue;
      pix.start_of_frame <= sof;
      pix.end_of_line    <= eol;
    end
  end

endmodule

@@ design/scrolling_color_bar_generator.sv @@
`timescale 1ns / 1ps
// a pixel request accepted while idle runs calc, prep and the 13-step bar-index divider, then
// waits in done until the output register is free; no new request is taken until then
// a request with advance low is taken while idle and gives no pixel
// a finished pixel waits in the output register while the next request runs
// reset (rst, synchronous): 1080 x 1920 frame, counters and scroll offset cleared

module scrolling_color_bar_generator #(
  parameter int MAX_LINES  = scb_pkg::MAX_LINES_DEF,
  parameter int MAX_PIXELS = scb_pkg::MAX_PIXELS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  scb_cfg_if.sink   cfg,   // register writes: frame_rows, frame_cols
  scb_req_if.sink   req,   // pixel requests
  scb_pix_if.source pix    // generated pixels
);
  import scb_pkg::*;

  // command and status between the sequencer and the datapath
  scb_cmd_t    cmd;
  scb_status_t status;

  // sequencer: accept request, latch geometry, prepare dividend and step
  // counters, run the divider, then hand the pixel to the output register
  scb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .status (status),
    .cmd    (cmd)
  );

  // datapath: config registers, raster counters, scroll offset, divider,
  // color lookup and output register
  scb_datapath #(
    .MAX_LINES  (MAX_LINES),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pix    (pix),
    .cmd    (cmd),
    .status (status)
  );

endmodule
